// ===== sv/bba_pkg.sv =====
// Shared types and constants for the block bitmap allocator.
package bba_pkg;

  localparam int BLK_W      = 12;
  localparam int CNT_W      = 13;
  localparam int GRANT_LIM  = 4096;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_BLOCKS = 1'b0,
    REG_FIRST_DATA   = 1'b1
  } reg_idx_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

endpackage

// ===== sv/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/block_bitmap_allocator_top.sv =====
// Block bitmap allocator: one used/free bit per block, held in words of a
// synchronous RAM. An allocate request scans from word 0 one word per cycle
// (pipelined read, priority encoder on the returned word) and takes the lowest
// free block at or above first_data_block and below min(total_blocks, NBLOCKS,
// 4096). A free request finds the word index by a reciprocal multiply, then
// reads the word, clears the block's bit and writes the word back; an invalid
// free goes straight to the result. One request is worked on at a time; a
// finished result waits in the output register while the next request is taken.
// After reset the map is cleared one word per cycle, ceil(min(NBLOCKS, 4096) /
// MAP_WORD_BITS) words (64 at the defaults), during which no request is taken;
// configuration writes are taken at any time.
module block_bitmap_allocator_top #(
  parameter int NBLOCKS       = 4096,
  parameter int MAP_WORD_BITS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bba_pkg::CNT_W-1:0]            cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [bba_pkg::IN_DATA_W-1:0]        in_tdata,   // [11:0] blk_id
  input  logic                                 in_tuser,   // [0] opcode
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [bba_pkg::OUT_DATA_W-1:0]       out_tdata   // [1:0] status, [13:2] granted_block
);

  import bba_pkg::*;

  localparam int EFF   = (NBLOCKS < GRANT_LIM) ? NBLOCKS : GRANT_LIM;
  localparam int WORDS = (EFF + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BW    = $clog2(MAP_WORD_BITS);
  localparam int SH    = BLK_W + 7;
  localparam int RECIP = ((1 << SH) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int MW    = MAP_WORD_BITS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_FDIV, S_FRD, S_FWR, S_DONE
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] total_r, first_r;
  logic [AW-1:0]    clr_r;
  logic [AW-1:0]    rd_w_r, chk_w_r;
  logic [CNT_W-1:0] rd_base_r, chk_base_r;
  logic             chk_v_r;
  logic [BLK_W-1:0] blk_r;
  logic [AW-1:0]    q_r;
  logic [BW-1:0]    rem_r;
  status_t          res_status_r;
  logic [BLK_W-1:0] res_grant_r;
  logic             out_valid_r;
  status_t          out_status_r;
  logic [BLK_W-1:0] out_grant_r;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [MW-1:0]    mem_wdata, mem_rdata;

  logic [CNT_W-1:0] limit;
  logic             issue;
  logic [CNT_W:0]   diff_lo, diff_hi;
  logic [MW-1:0]    lo_mask, hi_mask, cand;
  logic             hit;
  logic [BW-1:0]    hit_idx;
  logic [BLK_W-1:0] hit_grant;
  logic [31:0]      prod;
  logic [CNT_W-1:0] qmul;
  logic             free_bad;
  logic             in_acc;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_grant_r, out_status_r};

  assign limit = (total_r > CNT_W'(EFF)) ? CNT_W'(EFF) : total_r;
  assign issue = (state_r == S_SCAN) && (rd_base_r < limit);

  assign diff_lo = {1'b0, first_r} - {1'b0, chk_base_r};
  assign diff_hi = {1'b0, limit} - {1'b0, chk_base_r};

  always_comb begin
    if (diff_lo[CNT_W] || diff_lo == '0) begin
      lo_mask = '1;
    end else if (diff_lo >= (CNT_W+1)'(MW)) begin
      lo_mask = '0;
    end else begin
      lo_mask = {MW{1'b1}} << diff_lo[BW-1:0];
    end
    if (diff_hi[CNT_W] || diff_hi == '0) begin
      hi_mask = '0;
    end else if (diff_hi >= (CNT_W+1)'(MW)) begin
      hi_mask = '1;
    end else begin
      hi_mask = ~({MW{1'b1}} << diff_hi[BW-1:0]);
    end
  end

  assign cand = ~mem_rdata & lo_mask & hi_mask;
  assign hit  = chk_v_r && (cand != '0);

  always_comb begin
    hit_idx = '0;
    for (int i = MW - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_idx = BW'(i);
      end
    end
  end

  assign hit_grant = BLK_W'(chk_base_r + CNT_W'(hit_idx));

  assign prod     = 32'(blk_r) * 32'(RECIP);
  assign qmul     = CNT_W'(32'(q_r) * 32'(MW));
  assign free_bad = ({1'b0, in_tdata[BLK_W-1:0]} < first_r) ||
                    ({1'b0, in_tdata[BLK_W-1:0]} >= total_r) ||
                    ({1'b0, in_tdata[BLK_W-1:0]} >= CNT_W'(EFF));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_r;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = rd_w_r;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_SCAN: begin
        mem_re    = issue;
        mem_we    = hit;
        mem_waddr = chk_w_r;
        mem_wdata = mem_rdata | (MW'(1) << hit_idx);
      end
      S_FRD: begin
        mem_re    = 1'b1;
        mem_raddr = q_r;
      end
      S_FWR: begin
        mem_we    = 1'b1;
        mem_waddr = q_r;
        mem_wdata = mem_rdata & ~(MW'(1) << rem_r);
      end
      default: begin
      end
    endcase
  end

  bba_ram #(.WIDTH(MW), .DEPTH(WORDS)) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      total_r     <= CNT_W'(GRANT_LIM);
      first_r     <= '0;
      clr_r       <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TOTAL_BLOCKS: total_r <= cfg_wdata;
          REG_FIRST_DATA:   first_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(WORDS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            blk_r <= in_tdata[BLK_W-1:0];
            if (in_tuser == OP_ALLOC) begin
              rd_w_r    <= '0;
              rd_base_r <= '0;
              chk_v_r   <= 1'b0;
              state_r   <= S_SCAN;
            end else if (free_bad) begin
              res_status_r <= ST_INVALID;
              res_grant_r  <= '0;
              state_r      <= S_DONE;
            end else begin
              state_r <= S_FDIV;
            end
          end
        end
        S_SCAN: begin
          chk_v_r    <= issue && !hit;
          chk_w_r    <= rd_w_r;
          chk_base_r <= rd_base_r;
          rd_w_r     <= rd_w_r + AW'(1);
          rd_base_r  <= rd_base_r + CNT_W'(MW);
          if (hit) begin
            res_status_r <= ST_OK;
            res_grant_r  <= hit_grant;
            state_r      <= S_DONE;
          end else if (!issue && !chk_v_r) begin
            res_status_r <= ST_NOSPACE;
            res_grant_r  <= '0;
            state_r      <= S_DONE;
          end
        end
        S_FDIV: begin
          q_r     <= prod[SH +: AW];
          state_r <= S_FRD;
        end
        S_FRD: begin
          rem_r   <= BW'({1'b0, blk_r} - qmul);
          state_r <= S_FWR;
        end
        S_FWR: begin
          res_status_r <= ST_OK;
          res_grant_r  <= '0;
          state_r      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_grant_r  <= res_grant_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && hit) |-> ({1'b0, hit_grant} >= first_r && {1'b0, hit_grant} < limit))
    else $error("granted block outside the data area");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_grant_r == '0))
    else $error("failed request carries a block number");

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("request taken during map clear");

  a_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_SCAN || state_r == S_FWR))
    else $error("map write outside clear, scan or free");
`endif

endmodule
